FILE: hdl/mfps_pkg.sv
package mfps_pkg;

  localparam int COLS_MAX_DEF   = 1024;
  localparam int CELL_WIDTH_DEF = 16;
  localparam int SUM_W          = 32;
  localparam int CFG_W          = 11;

  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  // Per-beat control bits carried from the column scheduler to the datapath.
  typedef struct packed {
    logic last;       // final cell of the matrix
    logic first_row;  // no row above: sum is the cell itself
    logic row_end;    // no up-right neighbor
    logic col_zero;   // no up-left neighbor
  } cell_ctl_t;

  function automatic int col_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: hdl/mfps_if.sv
interface mfps_cell_if import mfps_pkg::*; #(
  parameter int CELL_W = CELL_WIDTH_DEF
) ();
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_value;
  logic                     last_cell;

  modport source (output valid, output cell_value, output last_cell, input ready);
  modport sink   (input valid, input cell_value, input last_cell, output ready);
endinterface

interface mfps_sum_if import mfps_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] max_sum;

  modport source (output valid, output max_sum, input ready);
  modport sink   (input valid, input max_sum, output ready);
endinterface

FILE: hdl/mfps_ram.sv
module mfps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: hdl/mfps_sched.sv
module mfps_sched import mfps_pkg::*; #(
  parameter int COLS_MAX   = COLS_MAX_DEF,
  parameter int CELL_WIDTH = CELL_WIDTH_DEF,
  localparam int COL_W     = col_bits(COLS_MAX)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_W-1:0]             cfg_wdata,
  mfps_cell_if.sink                    cells,
  input  logic                         advance,
  output logic                         s1_valid,
  output cell_ctl_t                    s1_ctl,
  output logic [COL_W-1:0]             s1_col,
  output logic signed [CELL_WIDTH-1:0] s1_cell,
  output logic                         rd_en,
  output logic [COL_W-1:0]             rd_addr0,
  output logic [COL_W-1:0]             rd_addr1
);

  localparam int CNT_W = ($clog2(COLS_MAX + 1) > CFG_W) ? $clog2(COLS_MAX + 1) : CFG_W;

  logic [CFG_W-1:0] row_width;
  logic [COL_W-1:0] column_index;
  logic             in_first_row;

  logic [COL_W-1:0] column_index_next;
  logic             in_first_row_next;
  logic [CNT_W-1:0] width_ext;
  logic [CNT_W-1:0] width_eff;
  logic [CNT_W-1:0] col_plus1;
  logic             row_end;
  logic             accept;
  cell_ctl_t        ctl;

  assign cells.ready = !s1_valid || advance;
  assign accept      = cells.valid && cells.ready;

  assign width_ext = CNT_W'(row_width);
  always_comb begin
    priority if (row_width == '0) begin
      width_eff = CNT_W'(1);
    end else if (width_ext > CNT_W'(COLS_MAX)) begin
      width_eff = CNT_W'(COLS_MAX);
    end else begin
      width_eff = width_ext;
    end
  end

  assign col_plus1 = CNT_W'(column_index) + CNT_W'(1);
  assign row_end   = (col_plus1 >= width_eff);

  assign ctl.last      = cells.last_cell;
  assign ctl.first_row = in_first_row;
  assign ctl.row_end   = row_end;
  assign ctl.col_zero  = (column_index == '0);

  // Fetch the up and up-right sums of the row above while the beat is captured.
  assign rd_en    = accept;
  assign rd_addr0 = column_index;
  assign rd_addr1 = row_end ? column_index : column_index + COL_W'(1);

  always_comb begin
    priority if (cells.last_cell) begin
      column_index_next = '0;
      in_first_row_next = 1'b1;
    end else if (row_end) begin
      column_index_next = '0;
      in_first_row_next = 1'b0;
    end else begin
      column_index_next = column_index + COL_W'(1);
      in_first_row_next = in_first_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width    <= CFG_W'(1);
      column_index <= '0;
      in_first_row <= 1'b1;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_width <= cfg_wdata;
      end
      if (accept) begin
        column_index <= column_index_next;
        in_first_row <= in_first_row_next;
        s1_valid     <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell <= cells.cell_value;
      s1_col  <= column_index;
      s1_ctl  <= ctl;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    column_index <= COL_W'(COLS_MAX - 1))
    else $error("column index beyond buffer depth");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && cells.last_cell |=> (column_index == '0) && in_first_row)
    else $error("matrix did not restart after last cell");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_col) && $stable(s1_cell))
    else $error("stalled beat lost from input stage");

endmodule

FILE: hdl/mfps_core.sv
module mfps_core import mfps_pkg::*; #(
  parameter int COLS_MAX   = COLS_MAX_DEF,
  parameter int CELL_WIDTH = CELL_WIDTH_DEF,
  localparam int COL_W     = col_bits(COLS_MAX)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s1_valid,
  input  cell_ctl_t                    s1_ctl,
  input  logic [COL_W-1:0]             s1_col,
  input  logic signed [CELL_WIDTH-1:0] s1_cell,
  input  logic                         rd_en,
  input  logic [COL_W-1:0]             rd_addr0,
  input  logic [COL_W-1:0]             rd_addr1,
  input  logic [SUM_W-1:0]             rd_data0,
  input  logic [SUM_W-1:0]             rd_data1,
  output logic                         advance,
  output logic                         wr_en,
  output logic [COL_W-1:0]             wr_addr,
  output logic [SUM_W-1:0]             wr_data,
  mfps_sum_if.source                   sums
);

  logic signed [SUM_W-1:0] left_sum;
  logic signed [SUM_W-1:0] run_max;
  logic                    out_valid;
  logic signed [SUM_W-1:0] out_data;
  logic                    fwd0;
  logic                    fwd1;
  logic signed [SUM_W-1:0] fwd_data;

  logic signed [SUM_W:0]   cell_ext;
  logic signed [SUM_W-1:0] centre;
  logic signed [SUM_W-1:0] right;
  logic signed [SUM_W-1:0] best;
  logic signed [SUM_W:0]   total;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] max_next;

  assign advance = s1_valid && (!s1_ctl.last || !out_valid || sums.ready);

  assign cell_ext = {{(SUM_W + 1 - CELL_WIDTH){s1_cell[CELL_WIDTH-1]}}, s1_cell};

  // The RAM returns old data when the entry is written in the read cycle.
  assign centre = fwd0 ? fwd_data : $signed(rd_data0);
  assign right  = fwd1 ? fwd_data : $signed(rd_data1);

  always_comb begin
    best = centre;
    if (!s1_ctl.col_zero && left_sum > best) begin
      best = left_sum;
    end
    if (!s1_ctl.row_end && right > best) begin
      best = right;
    end
  end

  assign total = cell_ext + {best[SUM_W-1], best};

  always_comb begin
    priority if (s1_ctl.first_row) begin
      sum = cell_ext[SUM_W-1:0];
    end else if (total[SUM_W] != total[SUM_W-1]) begin
      sum = total[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum = total[SUM_W-1:0];
    end
  end

  assign max_next = (sum > run_max) ? sum : run_max;

  assign wr_en   = advance;
  assign wr_addr = s1_col;
  assign wr_data = sum;

  assign sums.valid   = out_valid;
  assign sums.max_sum = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_max   <= SUM_MIN;
      out_valid <= 1'b0;
    end else begin
      if (sums.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        priority if (s1_ctl.last) begin
          out_valid <= 1'b1;
          run_max   <= SUM_MIN;
        end else if (s1_ctl.row_end) begin
          run_max <= SUM_MIN;
        end else begin
          run_max <= max_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_ctl.last) begin
      out_data <= max_next;
    end
    if (advance && !s1_ctl.first_row) begin
      left_sum <= centre;
    end
    if (rd_en) begin
      fwd0     <= wr_en && (rd_addr0 == wr_addr);
      fwd1     <= wr_en && (rd_addr1 == wr_addr);
      fwd_data <= sum;
    end
  end

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && s1_ctl.last))
    else $error("result raised without a last cell");

  a_max_grows: assert property (@(posedge clk) disable iff (rst)
    advance && !s1_ctl.last && !s1_ctl.row_end |=> run_max >= $past(run_max))
    else $error("row maximum decreased within a row");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sums.ready && s1_valid && s1_ctl.last |-> !advance)
    else $error("pending result overwritten");

endmodule

FILE: hdl/max_falling_path_sum.sv
// Channel  Dir  Payload                            Beat taken when
// cells    in   cell_value[CELL_WIDTH], last_cell  cells.valid && cells.ready
// sums     out  max_sum[32]                        sums.valid && sums.ready
// cfg      in   cfg_wdata[11] (row_width)          cfg_we
//
// One cell per cycle unless a held result stalls a last cell; a cell waits in the input
// stage while the row buffer RAM returns the sums above it, then is folded into the row.
// The result of a last cell is registered into the output once that cell leaves the input stage.
// Reset clears the column counter, row state and output; the row buffer is not cleared.
// A held result stalls only a following last cell; other cells keep flowing.
module max_falling_path_sum import mfps_pkg::*; #(
  parameter int COLS_MAX   = COLS_MAX_DEF,
  parameter int CELL_WIDTH = CELL_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  mfps_cell_if.sink        cells,
  mfps_sum_if.source       sums
);

  localparam int COL_W = col_bits(COLS_MAX);

  logic                         s1_valid;
  cell_ctl_t                    s1_ctl;
  logic [COL_W-1:0]             s1_col;
  logic signed [CELL_WIDTH-1:0] s1_cell;
  logic                         rd_en;
  logic [COL_W-1:0]             rd_addr0;
  logic [COL_W-1:0]             rd_addr1;
  logic [SUM_W-1:0]             rd_data0;
  logic [SUM_W-1:0]             rd_data1;
  logic                         advance;
  logic                         wr_en;
  logic [COL_W-1:0]             wr_addr;
  logic [SUM_W-1:0]             wr_data;

  mfps_sched #(
    .COLS_MAX  (COLS_MAX),
    .CELL_WIDTH(CELL_WIDTH)
  ) u_sched (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cells    (cells),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_col   (s1_col),
    .s1_cell  (s1_cell),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1)
  );

  mfps_ram #(
    .WIDTH(SUM_W),
    .DEPTH(COLS_MAX)
  ) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr0(rd_addr0),
    .raddr1(rd_addr1),
    .rdata0(rd_data0),
    .rdata1(rd_data1)
  );

  mfps_core #(
    .COLS_MAX  (COLS_MAX),
    .CELL_WIDTH(CELL_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .s1_valid(s1_valid),
    .s1_ctl  (s1_ctl),
    .s1_col  (s1_col),
    .s1_cell (s1_cell),
    .rd_en   (rd_en),
    .rd_addr0(rd_addr0),
    .rd_addr1(rd_addr1),
    .rd_data0(rd_data0),
    .rd_data1(rd_data1),
    .advance (advance),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .sums    (sums)
  );

endmodule

FILE: tb/tb_max_falling_path_sum.sv
`timescale 1ns / 100ps

module tb_max_falling_path_sum;
  import mfps_pkg::*;

  localparam int COLS     = COLS_MAX_DEF;
  localparam int CW       = CELL_WIDTH_DEF;
  localparam int SETTLE   = 4;
  localparam int HOLD_LEN = 300;
  localparam int WIDE_RUN = COLS + COLS / 16;  // one full widest row, then a short final row

  localparam logic signed [CW-1:0] CELL_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CELL_MAX = {1'b0, {(CW-1){1'b1}}};

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  mfps_cell_if #(.CELL_W(CW)) cell_bus ();
  mfps_sum_if                 sum_bus ();

  max_falling_path_sum #(.COLS_MAX(COLS), .CELL_WIDTH(CW)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cells     (cell_bus.sink),
    .sums      (sum_bus.source)
  );

  // path-sum tracker
  logic signed [SUM_W-1:0] prev_row [COLS];
  logic [9:0]              col_pos;
  logic                    top_row;
  logic signed [SUM_W-1:0] left_sum;
  logic signed [SUM_W-1:0] row_best;
  logic [CFG_W-1:0]        width_cfg;
  int                      filled_cols;  // buffer entries written since reset form a prefix
  logic signed [SUM_W-1:0] pending_max [$];
  logic signed [SUM_W-1:0] want;

  int err_count = 0;
  int sent;
  bit quiet;
  bit hold_pending;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int eff_width(input logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > COLS) return COLS;
    return int'(w);
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp_sum(input longint v);
    if (v > longint'(SUM_MAX)) return SUM_MAX;
    if (v < longint'(SUM_MIN)) return SUM_MIN;
    return v[SUM_W-1:0];
  endfunction

  function automatic void restart_matrix();
    col_pos  = '0;
    top_row  = 1'b1;
    left_sum = '0;
    row_best = SUM_MIN;
  endfunction

  function automatic void fold_cell(input logic signed [CW-1:0] v, input logic is_last);
    int                      j;
    int                      w;
    bit                      row_end;
    logic signed [SUM_W-1:0] centre;
    logic signed [SUM_W-1:0] best;
    logic signed [SUM_W-1:0] s;
    w = eff_width(width_cfg);
    j = int'(col_pos);
    if (j >= COLS) j = COLS - 1;
    row_end = (j + 1 >= w);
    if (top_row) begin
      s = SUM_W'(v);
    end else begin
      centre = prev_row[j];
      best   = centre;
      if (j > 0 && left_sum > best) best = left_sum;
      if (!row_end && prev_row[j+1] > best) best = prev_row[j+1];
      s = clamp_sum(longint'(v) + longint'(best));
      left_sum = centre;
    end
    prev_row[j] = s;
    if (j + 1 > filled_cols) filled_cols = j + 1;
    if (s > row_best) row_best = s;
    if (is_last) begin
      pending_max.push_back(row_best);
      restart_matrix();
    end else if (row_end) begin
      col_pos  = '0;
      top_row  = 1'b0;
      left_sum = '0;
      row_best = SUM_MIN;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  // result check first: a result always belongs to an earlier beat
  always @(posedge clk) begin
    if (rst) begin
      width_cfg   = 11'd1;
      filled_cols = 0;
      restart_matrix();
    end else begin
      if (sum_bus.valid && sum_bus.ready) begin
        if (pending_max.size() == 0) begin
          err_count++;
          $display("%0t: unexpected max_sum, expected none, got %0d", $time, sum_bus.max_sum);
        end else begin
          want = pending_max.pop_front();
          if (sum_bus.max_sum !== want) begin
            err_count++;
            $display("%0t: max_sum mismatch, expected %0d, got %0d",
                     $time, want, sum_bus.max_sum);
          end
        end
      end
      if (cell_bus.valid && cell_bus.ready) fold_cell(cell_bus.cell_value, cell_bus.last_cell);
      if (cfg_we) width_cfg = cfg_wdata;
    end
  end

  initial begin : sum_sink
    int hold_left;
    bit hold_seen;
    hold_left     = 0;
    hold_seen     = 1'b0;
    sum_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        sum_bus.ready <= 1'b0;
      end else begin
        sum_bus.ready <= quiet || ($urandom_range(99) >= 26);
      end
    end
  end

  function automatic logic signed [CW-1:0] pick_cell();
    logic signed [CW-1:0] v;
    case ($urandom_range(9))
      0: v = CELL_MIN;
      1: v = CELL_MAX;
      2, 3: begin
        v = CW'(int'($urandom_range(40)) - 20);
      end
      default: v = CW'($urandom());
    endcase
    return v;
  endfunction

  task automatic send_cell(input logic signed [CW-1:0] v, input logic is_last);
    while (!quiet && $urandom_range(99) < 26) begin
      @(negedge clk);
      cell_bus.valid <= 1'b0;
    end
    @(negedge clk);
    cell_bus.valid      <= 1'b1;
    cell_bus.cell_value <= v;
    cell_bus.last_cell  <= is_last;
    do @(posedge clk); while (!cell_bus.ready);
    sent++;
  endtask

  // drop valid, let results drain and the input stage empty
  task automatic wait_idle();
    @(negedge clk);
    cell_bus.valid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] w);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_directed();
    // single-cell matrices at the cell extremes, reset width of one
    send_cell(CELL_MAX, 1'b1);
    send_cell(CELL_MIN, 1'b1);
    set_width(11'd3);
    send_cell(CELL_MIN, 1'b0);
    send_cell(CELL_MAX, 1'b0);
    send_cell(16'sd0, 1'b0);
    send_cell(16'sd5, 1'b0);
    send_cell(-16'sd1, 1'b0);
    send_cell(16'sd7, 1'b0);
    send_cell(16'sd1, 1'b1);  // short final row
    set_width(11'd0);         // zero acts as one column
    send_cell(16'sd100, 1'b0);
    send_cell(-16'sd3, 1'b1);
    set_width(11'h7FF);       // clamps to the buffer depth
    send_cell(16'sd9, 1'b0);
    send_cell(CELL_MIN, 1'b0);
    send_cell(CELL_MAX, 1'b1);
    set_width(11'd4);
    repeat (7) send_cell(pick_cell(), 1'b0);
    set_width(11'd2);         // column 3 already past the new last column
    send_cell(pick_cell(), 1'b0);
    send_cell(pick_cell(), 1'b0);
    send_cell(pick_cell(), 1'b1);
  endtask

  // no idling on either side for the whole stretch
  task automatic test_widest_row();
    set_width(CFG_W'(COLS));
    quiet = 1'b1;
    for (int i = 0; i < WIDE_RUN; i++) send_cell(pick_cell(), i == WIDE_RUN - 1);
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    set_width(11'd1);
    hold_pending = 1'b1;
    // results pile up behind the held sink, so a later last beat must stall
    for (int i = 0; i < 40; i++) send_cell(pick_cell(), i < 3 || $urandom_range(1));
  endtask

  task automatic test_random(input int n_items);
    int               first;
    int               n_cells;
    int               we;
    int               lim;
    logic [CFG_W-1:0] w;
    int               r;
    first = sent;
    while (sent - first < n_items) begin
      r = $urandom_range(99);
      if (r < 80) w = CFG_W'($urandom_range(1, 8));
      else if (r < 93) w = CFG_W'($urandom_range(9, 64));
      else if (r < 96) w = '0;
      else w = CFG_W'($urandom_range(COLS + 1, 2047));
      set_width(w);
      we = eff_width(w);
      if (w > COLS) begin
        n_cells = $urandom_range(1, 20);
      end else begin
        n_cells = we * $urandom_range(1, 5);
        if ($urandom_range(3) == 0) n_cells = n_cells - $urandom_range(0, we - 1);
      end
      for (int i = 0; i < n_cells; i++) begin
        if (i > 0 && $urandom_range(49) == 0) begin
          // mid-matrix change; never widen past what the buffer already holds
          wait_idle();
          lim = top_row ? 64 : (filled_cols < 64 ? filled_cols : 64);
          set_width(CFG_W'($urandom_range(0, lim)));
        end
        send_cell(pick_cell(), i == n_cells - 1);
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    cell_bus.valid      = 1'b0;
    cell_bus.cell_value = '0;
    cell_bus.last_cell  = 1'b0;
    sent                = 0;
    quiet               = 1'b0;
    hold_pending        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_widest_row();
    test_backpressure();
    test_random(800);
    wait_idle();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
